// ===== rtl/dfoi_pkg.sv =====
// ----------------------------------------------------------------------------
// dfoi_pkg: shared types, constants and hash helpers
// FNV-1a 64 constants, tag seeds and the byte round used by the hash pipeline.
// ----------------------------------------------------------------------------
package dfoi_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MSG_W      = 3 * WORD_W;
    localparam int unsigned ROUNDS     = MSG_W / BYTE_W;
    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [WORD_W-1:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [WORD_W-1:0] TAG_HI     = 64'h7265_7761_7264_2D31;
    localparam logic [WORD_W-1:0] TAG_LO     = 64'h636C_6169_6D2D_7631;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

    // One FNV-1a step. Prime is 2^40 + 0x1B3, so the product is shifts and adds.
    function automatic logic [WORD_W-1:0] fnv_round(input logic [WORD_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] x;
        x = acc ^ {{(WORD_W-BYTE_W){1'b0}}, b & BYTE_MASK};
        return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
               + (x << 1);
    endfunction

    // Folds a whole word, low byte first. Used for the constant tag prefix only.
    function automatic logic [WORD_W-1:0] fnv_fold_word(input logic [WORD_W-1:0] acc,
                                                        input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] a;
        a = acc;
        for (int k = 0; k < WORD_W / BYTE_W; k++) begin
            a = fnv_round(a, w[k*BYTE_W +: BYTE_W]);
        end
        return a;
    endfunction

    localparam logic [WORD_W-1:0] SEED_HI = fnv_fold_word(FNV_BASIS, TAG_HI);
    localparam logic [WORD_W-1:0] SEED_LO = fnv_fold_word(FNV_BASIS, TAG_LO);

    // Byte streams for both hashes, low byte first.
    typedef struct packed {
        logic [MSG_W-1:0] msg_hi;
        logic [MSG_W-1:0] msg_lo;
    } t_msg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/dfoi_if.sv =====
// ----------------------------------------------------------------------------
// dfoi_if: item channels
// Valid/ready channels for the request item and the operation-id item.
// ----------------------------------------------------------------------------
interface dfoi_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] profile_high;
    logic [63:0] profile_low;
    logic [63:0] dedup_key;

    modport source (output valid, output profile_high, output profile_low,
                    output dedup_key, input ready);
    modport sink   (input valid, input profile_high, input profile_low,
                    input dedup_key, output ready);
endinterface

interface dfoi_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] op_id_high;
    logic [63:0] op_id_low;

    modport source (output valid, output op_id_high, output op_id_low, input ready);
    modport sink   (input valid, input op_id_high, input op_id_low, output ready);
endinterface

// ===== rtl/dfoi_front.sv =====
// ----------------------------------------------------------------------------
// dfoi_front: input stage
// Registers each item and lays out the byte stream of each hash.
// ----------------------------------------------------------------------------
module dfoi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dfoi_in_if.sink         i_in,
    input  dfoi_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output dfoi_pkg::t_msg  o_msg
);
    import dfoi_pkg::*;

    logic r_vld, n_vld;
    t_msg r_msg;
    logic w_acc;

    assign i_in.ready = !r_vld || !i_q_stat.full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign o_push     = r_vld && !i_q_stat.full;
    assign o_msg      = r_msg;

    always_comb begin
        n_vld = r_vld;
        if (w_acc) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // High hash: ph, pl, key. Low hash: key, pl, ph.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_msg.msg_hi <= {i_in.dedup_key, i_in.profile_low, i_in.profile_high};
            r_msg.msg_lo <= {i_in.profile_high, i_in.profile_low, i_in.dedup_key};
        end
    end
endmodule

// ===== rtl/dfoi_fifo.sv =====
// ----------------------------------------------------------------------------
// dfoi_fifo: decoupling queue
// Short register queue between the input stage and the hash pipeline.
// ----------------------------------------------------------------------------
module dfoi_fifo #(
    parameter int unsigned DEPTH = dfoi_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dfoi_pkg::t_msg    i_msg,
    input  logic              i_pop,
    output dfoi_pkg::t_msg    o_msg,
    output dfoi_pkg::t_q_stat o_stat
);
    import dfoi_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_msg          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_msg        = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_msg;
        end
    end
endmodule

// ===== rtl/dfoi_back.sv =====
// ----------------------------------------------------------------------------
// dfoi_back: hash pipeline
// One byte round of both hashes per stage, then the all-zero fix-up.
// ----------------------------------------------------------------------------
module dfoi_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dfoi_pkg::t_msg    i_msg,
    input  dfoi_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    dfoi_out_if.source        o_out
);
    import dfoi_pkg::*;

    logic              r_vld [ROUNDS];
    logic [WORD_W-1:0] r_hi  [ROUNDS];
    logic [WORD_W-1:0] r_lo  [ROUNDS];
    logic [MSG_W-1:0]  r_mhi [ROUNDS];
    logic [MSG_W-1:0]  r_mlo [ROUNDS];
    logic              r_ovld;
    logic [WORD_W-1:0] r_ohi, r_olo;
    logic              w_en;
    logic [WORD_W-1:0] w_fix_lo;

    // Whole pipe moves together; it holds only when the output item waits.
    assign w_en  = !r_ovld || o_out.ready;
    assign o_pop = w_en && !i_q_stat.empty;

    assign w_fix_lo = (r_hi[ROUNDS-1] == '0 && r_lo[ROUNDS-1] == '0)
                    ? WORD_W'(1) : r_lo[ROUNDS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROUNDS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= !i_q_stat.empty;
            for (int k = 1; k < ROUNDS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hi[0]  <= fnv_round(SEED_HI, i_msg.msg_hi[BYTE_W-1:0]);
            r_lo[0]  <= fnv_round(SEED_LO, i_msg.msg_lo[BYTE_W-1:0]);
            r_mhi[0] <= i_msg.msg_hi >> BYTE_W;
            r_mlo[0] <= i_msg.msg_lo >> BYTE_W;
            for (int k = 1; k < ROUNDS; k++) begin
                r_hi[k]  <= fnv_round(r_hi[k-1], r_mhi[k-1][BYTE_W-1:0]);
                r_lo[k]  <= fnv_round(r_lo[k-1], r_mlo[k-1][BYTE_W-1:0]);
                r_mhi[k] <= r_mhi[k-1] >> BYTE_W;
                r_mlo[k] <= r_mlo[k-1] >> BYTE_W;
            end
            r_ohi <= r_hi[ROUNDS-1];
            r_olo <= w_fix_lo;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.op_id_high = r_ohi;
    assign o_out.op_id_low  = r_olo;
endmodule

// ===== rtl/dual_fnv1a_operation_id.sv =====
// ----------------------------------------------------------------------------
// dual_fnv1a_operation_id: 128-bit operation id from profile id and dedup key
// Two FNV-1a 64 hashes over tagged 32-byte streams, pipelined.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while its output is not stalled and
// returns one operation id per item, in order. Each id word is FNV-1a 64 over
// a 64-bit tag and the three input words, all little-endian; the tag prefix
// is folded at elaboration, so the pipeline runs the 24 remaining byte
// rounds of both hashes, one round per stage. From input accept to output
// valid an item passes the input register, the queue, 24 round stages and
// the output register that also replaces an all-zero id by low word 1.
// The byte-round pipeline sets that rate. The queue (FIFO_DEPTH items)
// lets the input side keep accepting while the output is stalled; when it
// is full and the input register holds an item, i_in.ready drops.
// ----------------------------------------------------------------------------
module dual_fnv1a_operation_id #(
    parameter int unsigned FIFO_DEPTH = dfoi_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfoi_in_if.sink    i_in,
    dfoi_out_if.source o_out
);
    import dfoi_pkg::*;

    t_msg    w_front_msg;
    t_msg    w_q_msg;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    // Front: registers the item and builds both byte streams.
    dfoi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_msg    (w_front_msg)
    );

    // Queue between front and hash pipeline.
    dfoi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_msg   (w_front_msg),
        .i_pop   (w_pop),
        .o_msg   (w_q_msg),
        .o_stat  (w_q_stat)
    );

    // Back: byte-round pipeline and output register.
    dfoi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (w_q_msg),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // The all-zero id is never delivered.
    a_no_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.op_id_high != '0 || o_out.op_id_low != '0))
        else $error("all-zero operation id delivered");

    // Queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("queue pop while empty");

    // Nothing comes out right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
